// File: hw/rtl/xrgb8888_pixel_format_converter_assert.svh
// ----------------------------------------------------------------------------
// XRGB8888 pixel format converter assertion macros
// Clocked property wrappers shared by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef XRGB8888_PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define XRGB8888_PIXEL_FORMAT_CONVERTER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define XPFC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger at one edge implies the condition at the next edge.
`define XPFC_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: hw/rtl/xpfc_pkg.sv
// ----------------------------------------------------------------------------
// XRGB8888 pixel format converter package
// Format codes, register indexes and the result type of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xpfc_pkg;

   // Target format codes; codes 12 to 15 are unsupported.
   typedef enum logic [3:0] {
      FMT_RGB565      = 4'd0,
      FMT_RGBA5551    = 4'd1,
      FMT_XRGB1555    = 4'd2,
      FMT_ARGB1555    = 4'd3,
      FMT_RGB888      = 4'd4,
      FMT_XRGB8888    = 4'd5,
      FMT_ARGB8888    = 4'd6,
      FMT_XBGR8888    = 4'd7,
      FMT_ABGR8888    = 4'd8,
      FMT_XRGB2101010 = 4'd9,
      FMT_ARGB2101010 = 4'd10,
      FMT_ABGR2101010 = 4'd11
   } format_type;

   // Register indexes (byte address = 4 * index).
   localparam int unsigned CSR_IDX_WIDTH = 1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_TARGET_FORMAT = 1'b0;

   localparam int unsigned PIXEL_WIDTH = 32;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_out;
      logic                   format_supported;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/xrgb8888_pixel_format_converter.sv
// ----------------------------------------------------------------------------
// XRGB8888 pixel format converter
// Repacks a stream of XRGB8888 pixels into a register-selected format.
//
// Usage:
//   req_*  : input stream, one XRGB8888 pixel per transaction in req_tdata.
//   rsp_*  : result stream, packed pixel in rsp_tdata, supported flag in
//            rsp_tuser. 16-bit formats use rsp_tdata[15:0], upper bits zero.
//   csr_*  : APB-style port; the target format register sits at address 0.
//            Change it only while no transaction is in flight.
//   An accepted request passes one input register stage, then the repack
//   logic into the result register, before it shows on rsp_tvalid.
//   Throughput is one pixel per clock while rsp_tready is high, set by the
//   two-stage register pipe. When rsp_tready is low the result register
//   holds, the input register holds once full, and req_tready drops only
//   when both stages are full. Reset empties both stages and selects RGB565.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xrgb8888_pixel_format_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] pixel_in
   // Result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] pixel_out
   output logic [0:0]       rsp_tuser,   // [0] format_supported
   // Configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

`include "xrgb8888_pixel_format_converter_assert.svh"

   xpfc_pkg::format_type target_format;

   // Stage 1: input register
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [31:0] s1_pixel_ff;
   logic [31:0] s1_pixel_in;

   // Stage 2: result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   xpfc_pkg::result_type rsp_result_ff;
   xpfc_pkg::result_type rsp_result_in;
   xpfc_pkg::result_type repacked;

   logic advance;
   logic req_take;

   xpfc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .target_format (target_format)
   );

   xpfc_repack u_repack (
      .pixel_in      (s1_pixel_ff),
      .target_format (target_format),
      .result        (repacked)
   );

   // Result register can take a new value when empty or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   // Input register can take a new pixel when empty or moving forward.
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_pixel_in   = s1_pixel_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;

      // Advance stage 1 into the result register.
      if (advance) begin
         rsp_valid_in  = s1_valid_ff;
         rsp_result_in = repacked;
         s1_valid_in   = 1'b0;
      end

      // Load a fresh pixel.
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_pixel_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_pixel_ff   <= s1_pixel_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_result_ff.pixel_out;
   assign rsp_tuser[0] = rsp_result_ff.format_supported;

   // An unsupported format always delivers a zero pixel.
   `XPFC_ASSERT_ALWAYS(a_unsupported_zero, clock, reset, !(rsp_valid_ff && !rsp_tuser[0]) || (rsp_tdata == 32'h0000_0000), "unsupported format with nonzero pixel")

   // An accepted request lands in the input register.
   `XPFC_ASSERT_NEXT(a_take_fills_s1, clock, reset, req_take, s1_valid_ff, "accepted pixel lost at input stage")

   // A blocked input stage keeps its pixel.
   `XPFC_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_pixel_ff), "input stage dropped a stalled pixel")

endmodule

`default_nettype wire

// File: hw/rtl/xpfc_csr.sv
// ----------------------------------------------------------------------------
// XRGB8888 pixel format converter register file
// APB-style port holding the target format register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xpfc_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic      [31:0]         csr_prdata,
   output logic                     csr_pready,
   output xpfc_pkg::format_type     target_format
);

   xpfc_pkg::format_type target_format_ff;
   xpfc_pkg::format_type target_format_in;
   logic [xpfc_pkg::CSR_IDX_WIDTH-1:0] reg_index;
   logic                               write_en;

   assign reg_index  = csr_paddr[2:2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      target_format_in = target_format_ff;
      if (write_en && (reg_index == xpfc_pkg::CSR_IDX_TARGET_FORMAT)) begin
         target_format_in = xpfc_pkg::format_type'(csr_pwdata[3:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_format_ff <= xpfc_pkg::FMT_RGB565;
      end else begin
         target_format_ff <= target_format_in;
      end
   end

   // Unmapped addresses read as zero.
   always_comb begin
      csr_prdata = 32'h0000_0000;
      if (reg_index == xpfc_pkg::CSR_IDX_TARGET_FORMAT) begin
         csr_prdata = {28'h000_0000, target_format_ff};
      end
   end

   assign target_format = target_format_ff;

endmodule

`default_nettype wire

// File: hw/rtl/xpfc_repack.sv
// ----------------------------------------------------------------------------
// XRGB8888 pixel format converter repacker
// Rewires one XRGB8888 pixel into the selected target format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xpfc_repack (
   input  wire logic [31:0]          pixel_in,
   input  wire xpfc_pkg::format_type target_format,
   output xpfc_pkg::result_type      result
);

   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   assign red   = pixel_in[23:16];
   assign green = pixel_in[15:8];
   assign blue  = pixel_in[7:0];

   always_comb begin
      result.format_supported = 1'b1;
      unique case (target_format)
         xpfc_pkg::FMT_RGB565: begin
            result.pixel_out = {16'h0000, red[7:3], green[7:2], blue[7:3]};
         end
         xpfc_pkg::FMT_RGBA5551: begin
            result.pixel_out = {16'h0000, red[7:3], green[7:3], blue[7:3], 1'b1};
         end
         xpfc_pkg::FMT_XRGB1555: begin
            result.pixel_out = {16'h0000, 1'b0, red[7:3], green[7:3], blue[7:3]};
         end
         xpfc_pkg::FMT_ARGB1555: begin
            result.pixel_out = {16'h0000, 1'b1, red[7:3], green[7:3], blue[7:3]};
         end
         xpfc_pkg::FMT_RGB888,
         xpfc_pkg::FMT_XRGB8888: begin
            result.pixel_out = pixel_in;
         end
         xpfc_pkg::FMT_ARGB8888: begin
            result.pixel_out = {8'hFF, pixel_in[23:0]};
         end
         xpfc_pkg::FMT_XBGR8888: begin
            result.pixel_out = {pixel_in[31:24], blue, green, red};
         end
         xpfc_pkg::FMT_ABGR8888: begin
            result.pixel_out = {8'hFF, blue, green, red};
         end
         // 10-bit channels: append the top two bits of each 8-bit channel.
         xpfc_pkg::FMT_XRGB2101010: begin
            result.pixel_out = {2'b00, red, red[7:6], green, green[7:6],
                                blue, blue[7:6]};
         end
         xpfc_pkg::FMT_ARGB2101010: begin
            result.pixel_out = {2'b11, red, red[7:6], green, green[7:6],
                                blue, blue[7:6]};
         end
         xpfc_pkg::FMT_ABGR2101010: begin
            result.pixel_out = {2'b11, blue, blue[7:6], green, green[7:6],
                                red, red[7:6]};
         end
         default: begin
            result.pixel_out        = 32'h0000_0000;
            result.format_supported = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire
